// File: hdl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: hdl/itpt_pkg.sv
package itpt_pkg;

    localparam int TASK_SLOTS_DEF = 64;

    localparam int TASK_W = 16;
    localparam int USER_W = 16;
    localparam int PRIO_W = 31;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_EDIT   = 2'd1,
        K_REMOVE = 2'd2,
        K_EXEC   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] task_id;
        logic [USER_W-1:0] user_id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic free_found;
        logic best_found;
    } t_scan_flags;

endpackage

// File: hdl/itpt_mem.sv
module itpt_mem #(
    parameter int DEPTH = itpt_pkg::TASK_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  itpt_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output itpt_pkg::t_entry o_rdata
);

    itpt_pkg::t_entry r_mem [DEPTH];
    itpt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/itpt_scan.sv
module itpt_scan #(
    parameter int AW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_vld,
    input  logic [AW-1:0]                 i_idx,
    input  itpt_pkg::t_entry              i_entry,
    input  logic [itpt_pkg::TASK_W-1:0]   i_key,
    output itpt_pkg::t_scan_flags         o_flags,
    output logic [AW-1:0]                 o_hit_idx,
    output logic [itpt_pkg::USER_W-1:0]   o_hit_user,
    output logic [AW-1:0]                 o_free_idx,
    output logic [AW-1:0]                 o_best_idx,
    output logic [itpt_pkg::USER_W-1:0]   o_best_user
);

    itpt_pkg::t_scan_flags             r_flags;
    logic [AW-1:0]                     r_hit_idx;
    logic [itpt_pkg::USER_W-1:0]       r_hit_user;
    logic [AW-1:0]                     r_free_idx;
    logic [AW-1:0]                     r_best_idx;
    logic [itpt_pkg::USER_W-1:0]       r_best_user;
    logic [itpt_pkg::PRIO_W-1:0]       r_best_prio;
    logic [itpt_pkg::TASK_W-1:0]       r_best_task;

    logic n_take_hit;
    logic n_take_free;
    logic n_take_best;

    always_comb begin
        n_take_hit  = i_vld && i_entry.valid && (i_entry.task_id == i_key) && !r_flags.hit;
        n_take_free = i_vld && !i_entry.valid && !r_flags.free_found;
        n_take_best = i_vld && i_entry.valid &&
                      (!r_flags.best_found ||
                       ({i_entry.prio, i_entry.task_id} > {r_best_prio, r_best_task}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
        end else begin
            if (n_take_hit) begin
                r_flags.hit <= 1'b1;
            end
            if (n_take_free) begin
                r_flags.free_found <= 1'b1;
            end
            if (n_take_best) begin
                r_flags.best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take_hit) begin
            r_hit_idx  <= i_idx;
            r_hit_user <= i_entry.user_id;
        end
        if (n_take_free) begin
            r_free_idx <= i_idx;
        end
        if (n_take_best) begin
            r_best_idx  <= i_idx;
            r_best_user <= i_entry.user_id;
            r_best_prio <= i_entry.prio;
            r_best_task <= i_entry.task_id;
        end
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_user  = r_hit_user;
    assign o_free_idx  = r_free_idx;
    assign o_best_idx  = r_best_idx;
    assign o_best_user = r_best_user;

endmodule

// File: hdl/indexed_priority_task_table.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-----------------------------------------
// in      | input     | i_valid / o_ready  | i_kind, i_task_id, i_user_id, i_priority_req
// out     | output    | o_valid / i_ready  | o_status, o_served_user
//
// Each item scans every slot through the single read port of the slot memory,
// one slot per cycle, then writes back at most once; the next item is taken the
// cycle after the result is loaded. After reset a clearing pass writes every slot
// with o_ready low. A stalled result waits in the output register; the next item
// is still scanned, but its result holds the sequencer until the register is free.
`include "assert_macros.svh"

module indexed_priority_task_table #(
    parameter int TASK_SLOTS = itpt_pkg::TASK_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_kind,
    input  logic [itpt_pkg::TASK_W-1:0]     i_task_id,
    input  logic [itpt_pkg::USER_W-1:0]     i_user_id,
    input  logic [itpt_pkg::PRIO_W-1:0]     i_priority_req,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [itpt_pkg::STATUS_W-1:0]   o_status,
    output logic [itpt_pkg::USER_W-1:0]     o_served_user
);

    localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(TASK_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WB,
        S_PUT
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_addr;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_idx;
    itpt_pkg::t_kind                 r_kind;
    logic [itpt_pkg::TASK_W-1:0]     r_task;
    logic [itpt_pkg::USER_W-1:0]     r_user;
    logic [itpt_pkg::PRIO_W-1:0]     r_prio;
    itpt_pkg::t_status               r_res_status;
    logic [itpt_pkg::USER_W-1:0]     r_res_served;
    logic                            r_out_valid;
    itpt_pkg::t_status               r_out_status;
    logic [itpt_pkg::USER_W-1:0]     r_out_served;

    logic                            n_rd_en;
    logic                            n_we;
    logic [AW-1:0]                   n_waddr;
    itpt_pkg::t_entry                n_wdata;
    itpt_pkg::t_status               n_status;
    logic [itpt_pkg::USER_W-1:0]     n_served;

    itpt_pkg::t_entry                rd_data;
    itpt_pkg::t_scan_flags           scan_flags;
    logic [AW-1:0]                   hit_idx;
    logic [itpt_pkg::USER_W-1:0]     hit_user;
    logic [AW-1:0]                   free_idx;
    logic [AW-1:0]                   best_idx;
    logic [itpt_pkg::USER_W-1:0]     best_user;

    assign n_rd_en = (r_state == S_SCAN);

    itpt_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_re    (n_rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    itpt_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (r_state == S_IDLE),
        .i_vld       (r_rd_vld),
        .i_idx       (r_rd_idx),
        .i_entry     (rd_data),
        .i_key       (r_task),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_hit_user  (hit_user),
        .o_free_idx  (free_idx),
        .o_best_idx  (best_idx),
        .o_best_user (best_user)
    );

    // Write-back decision, taken once the scan has seen every slot; the clearing pass writes zero to every slot.
    always_comb begin
        n_we     = 1'b0;
        n_waddr  = r_addr;
        n_wdata  = '0;
        n_status = itpt_pkg::ST_OK;
        n_served = '0;
        if (r_state == S_CLEAR) begin
            n_we = 1'b1;
        end else if (r_state == S_WB) begin
            unique case (r_kind)
                itpt_pkg::K_ADD: begin
                    if (scan_flags.hit) begin
                        n_status = itpt_pkg::ST_DUPLICATE;
                    end else if (!scan_flags.free_found) begin
                        n_status = itpt_pkg::ST_FULL;
                    end else begin
                        n_we    = 1'b1;
                        n_waddr = free_idx;
                        n_wdata = '{valid: 1'b1, task_id: r_task, user_id: r_user,
                                    prio: r_prio};
                    end
                end
                itpt_pkg::K_EDIT: begin
                    if (!scan_flags.hit) begin
                        n_status = itpt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_we    = 1'b1;
                        n_waddr = hit_idx;
                        n_wdata = '{valid: 1'b1, task_id: r_task, user_id: hit_user,
                                    prio: r_prio};
                    end
                end
                itpt_pkg::K_REMOVE: begin
                    if (!scan_flags.hit) begin
                        n_status = itpt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_we    = 1'b1;
                        n_waddr = hit_idx;
                    end
                end
                itpt_pkg::K_EXEC: begin
                    if (!scan_flags.best_found) begin
                        n_status = itpt_pkg::ST_EMPTY;
                    end else begin
                        n_we     = 1'b1;
                        n_waddr  = best_idx;
                        n_served = best_user;
                    end
                end
                default: begin
                    n_status = itpt_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= n_rd_en;
            r_rd_idx <= r_addr;
            if (r_out_valid && i_ready && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= itpt_pkg::t_kind'(i_kind);
                        r_task  <= i_task_id;
                        r_user  <= i_user_id;
                        r_prio  <= i_priority_req;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_res_status <= n_status;
                    r_res_served <= n_served;
                    r_state      <= S_PUT;
                end
                S_PUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_served <= r_res_served;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_served_user = r_out_served;

    `ASSERT_NEVER(a_wr_rd_overlap, i_clk, i_rst_n, n_we && n_rd_en, "write during scan read")
    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "second item taken during scan")
    `ASSERT_CLK(a_out_from_put, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == S_PUT), "result loaded outside put")
    `ASSERT_CLK(a_served_ok, i_clk, i_rst_n, (o_valid && (o_served_user != '0)) |-> (o_status == itpt_pkg::ST_OK), "served user with error status")

endmodule
